// ----- rtl/core/div64_pkg.sv -----
package div64_pkg;

    typedef enum logic [1:0] {
        OP_UQUO = 2'd0,
        OP_UREM = 2'd1,
        OP_SQUO = 2'd2,
        OP_SREM = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_WIDE = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    localparam int DW = 64;
    localparam int MW = 32;

    // classified item handed from front to back
    typedef struct packed {
        logic [DW-1:0] mag_a;
        logic [MW-1:0] mag_b;
        logic [DW-1:0] raw_a;
        logic          want_rem;
        logic          neg_q;
        logic          neg_r;
        status_t       status;
    } job_t;

endpackage

// ----- rtl/core/div64_front.sv -----
module div64_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [63:0]       dividend,
    input  logic [63:0]       divisor,
    output logic              job_valid,
    input  logic              job_ready,
    output div64_pkg::job_t   job
);
    import div64_pkg::*;

    logic          valid_reg;
    job_t          job_reg;
    job_t          job_next;
    logic          is_signed;
    logic          neg_a;
    logic          neg_b;
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        is_signed = operation[1];
        neg_a     = is_signed && dividend[DW-1];
        neg_b     = is_signed && divisor[DW-1];
        ma        = neg_a ? (~dividend + 64'd1) : dividend;
        mb        = neg_b ? (~divisor + 64'd1) : divisor;
        job_next.mag_a    = ma;
        job_next.mag_b    = mb[MW-1:0];
        job_next.raw_a    = dividend;
        job_next.want_rem = operation[0];
        job_next.neg_q    = neg_a ^ neg_b;
        job_next.neg_r    = neg_a;
        if (|mb[DW-1:MW])
            job_next.status = ST_WIDE;
        else if (mb[MW-1:0] == '0)
            job_next.status = ST_ZERO;
        else
            job_next.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            job_reg <= job_next;
    end

endmodule

// ----- rtl/core/div64_queue.sv -----
module div64_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  div64_pkg::job_t   wr_job,
    output logic              rd_valid,
    input  logic              rd_ready,
    output div64_pkg::job_t   rd_job
);
    import div64_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("push into full queue");

endmodule

// ----- rtl/core/div64_back.sv -----
module div64_back #(
    parameter int DIGIT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  div64_pkg::job_t   job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       result,
    output logic [1:0]        status
);
    import div64_pkg::*;

    localparam int STEP_MAX = 4;
    localparam int SB = (DIGIT_BITS < STEP_MAX) ? DIGIT_BITS : STEP_MAX;
    localparam int NS = (DW + SB - 1) / SB;

    // stage s handles quotient bits from the top down, up to SB restoring steps each
    logic          v_reg   [NS+1];
    job_t          j_reg   [NS+1];
    logic [DW-1:0] q_reg   [NS+1];
    logic [MW-1:0] r_reg   [NS+1];
    logic          adv     [NS+1];
    logic [63:0]   res_c;

    assign adv[NS] = !v_reg[NS] || out_ready;
    for (genvar s = NS - 1; s >= 0; s--)
    begin : g_adv
        assign adv[s] = !v_reg[s] || adv[s+1];
    end
    assign job_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv[0])
            v_reg[0] <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && job_valid)
        begin
            j_reg[0] <= job;
            q_reg[0] <= '0;
            r_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int LO = (NS - 1 - s) * SB;
        localparam int W  = (DW - LO < SB) ? (DW - LO) : SB;
        logic [MW-1:0] r_c;
        logic [DW-1:0] q_c;

        always_comb
        begin
            logic [MW:0] t;
            t   = '0;
            r_c = r_reg[s];
            q_c = q_reg[s];
            for (int k = W - 1; k >= 0; k--)
            begin
                t = {r_c, j_reg[s].mag_a[LO+k]};
                if (t >= {1'b0, j_reg[s].mag_b})
                begin
                    t = t - {1'b0, j_reg[s].mag_b};
                    q_c[LO+k] = 1'b1;
                end
                r_c = t[MW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (adv[s+1])
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv[s+1] && v_reg[s])
            begin
                j_reg[s+1] <= j_reg[s];
                q_reg[s+1] <= q_c;
                r_reg[s+1] <= r_c;
            end
        end
    end

    always_comb
    begin
        unique case (j_reg[NS].status)
            ST_WIDE: res_c = '0;
            ST_ZERO: res_c = j_reg[NS].want_rem ? j_reg[NS].raw_a : '1;
            default:
            begin
                if (j_reg[NS].want_rem)
                    res_c = j_reg[NS].neg_r ? (~{32'd0, r_reg[NS]} + 64'd1)
                                            : {32'd0, r_reg[NS]};
                else
                    res_c = j_reg[NS].neg_q ? (~q_reg[NS] + 64'd1) : q_reg[NS];
            end
        endcase
    end

    assign out_valid = v_reg[NS];
    assign result    = res_c;
    assign status    = j_reg[NS].status;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_WIDE) |-> result == '0)
        else $error("wide divisor result nonzero");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (j_reg[NS].mag_b != '0))
        else $error("ok status with zero divisor");

endmodule

// ----- rtl/core/divide_64_by_32_signed_unsigned.sv -----
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | operation, dividend, divisor
// out     | out_valid | out_ready | result, status
// One transfer per cycle sustained while out_ready is not held low;
// NS = ceil(64/min(DIGIT_BITS,4)) digit pipeline stages.
// Each pipeline stage resolves up to four quotient bits.
// Front register, two-entry queue, then the digit pipeline; each stalls alone.
// rst_n async active low clears all valid bits.
module divide_64_by_32_signed_unsigned #(
    parameter int DIGIT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result,
    output logic [1:0]  status
);
    import div64_pkg::*;

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    div64_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .dividend, .divisor,
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    div64_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
    );

    div64_back #(.DIGIT_BITS(DIGIT_BITS)) u_back (
        .clk, .rst_n,
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .out_valid, .out_ready, .result, .status
    );

endmodule
